// File: hdl/fbc_pkg.sv
// Shared types, constants and plane derivation for the frustum box cull block.
// No dependencies; every other file of the block imports this package.
package fbc_pkg;

	localparam int WORD_BITS       = 32;
	localparam int COEF_BITS       = 33;
	localparam int FRAC_BITS       = 16;
	localparam int PAIR_BITS       = 64;
	localparam int NUM_PAIRS       = 8;
	localparam int NUM_PLANES      = 6;
	localparam int NUM_SIDE_PLANES = 4;
	localparam int NUM_AXES        = 3;
	localparam int NUM_COLS        = 4;
	localparam int CFG_INDEX_BITS  = 4;

	// Row 4 of the matrix (index 3) is the common term of every plane.
	localparam logic [1:0] W_ROW = 2'd3;

	// Plane order: top, bottom, left, right, near, far.
	localparam logic [1:0] PLANE_ROW [NUM_PLANES] = '{2'd1, 2'd1, 2'd0, 2'd0, 2'd2, 2'd2};
	// Set where the plane is row 4 minus the listed row.
	localparam logic       PLANE_SUB [NUM_PLANES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

	typedef logic [NUM_PAIRS-1:0][PAIR_BITS-1:0] matrix_t;

	typedef struct packed {
		logic [NUM_AXES-1:0][COEF_BITS-1:0] a;
		logic [COEF_BITS-1:0]               d;
	} plane_t;

	typedef enum logic [1:0] {
		VERDICT_INSIDE    = 2'd0,
		VERDICT_INTERSECT = 2'd1,
		VERDICT_OUTSIDE   = 2'd2
	} verdict_t;

	// Stage advance strobes shared by the per-plane test slices.
	typedef struct packed {
		logic s2;
		logic s3;
	} adv_t;

	// Matrix element m(row, col), column-major, sign-extended to coefficient width.
	function automatic logic [COEF_BITS-1:0] mat_at(matrix_t m, logic [1:0] row,
			logic [1:0] col);
		logic [3:0]           w;
		logic [WORD_BITS-1:0] word;
		w    = {col, row};
		word = w[0] ? m[w[3:1]][PAIR_BITS-1:WORD_BITS] : m[w[3:1]][WORD_BITS-1:0];
		return {word[WORD_BITS-1], word};
	endfunction

	// Unnormalised clip plane: row 4 plus or minus the given row.
	function automatic plane_t make_plane(matrix_t m, logic [1:0] row, logic sub);
		plane_t               p;
		logic [COEF_BITS-1:0] base;
		logic [COEF_BITS-1:0] term;
		logic [COEF_BITS-1:0] coef;
		p = '0;
		for (int c = 0; c < NUM_COLS; c++) begin
			base = mat_at(m, W_ROW, 2'(c));
			term = mat_at(m, row, 2'(c));
			coef = sub ? (base - term) : (base + term);
			if (c < NUM_AXES) begin
				p.a[c] = coef;
			end else begin
				p.d = coef;
			end
		end
		return p;
	endfunction

endpackage

// File: hdl/fbc_box_if.sv
// Box input channel: valid/ready handshake with the six corner coordinates.
// Depends on fbc_pkg.
interface fbc_box_if import fbc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic signed [31:0] min_x;
	logic signed [31:0] min_y;
	logic signed [31:0] min_z;
	logic signed [31:0] max_x;
	logic signed [31:0] max_y;
	logic signed [31:0] max_z;
	logic               side_planes_only;

	modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z,
		side_planes_only, input ready);
	modport sink (input valid, min_x, min_y, min_z, max_x, max_y, max_z,
		side_planes_only, output ready);
endinterface

// File: hdl/fbc_verdict_if.sv
// Result channel: valid/ready handshake carrying one verdict per box.
// Depends on fbc_pkg.
interface fbc_verdict_if import fbc_pkg::*; ();
	logic     valid;
	logic     ready;
	verdict_t verdict;

	modport source (output valid, verdict, input ready);
	modport sink (input valid, verdict, output ready);
endinterface

// File: hdl/fbc_cfg_if.sv
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on fbc_pkg.
interface fbc_cfg_if import fbc_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [PAIR_BITS-1:0]      data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/frustum_box_cull.sv
// Top level of the frustum box cull block: handshakes, box stage, verdict stage.
// Depends on fbc_pkg, the three channel interfaces, fbc_plane_regs, fbc_side_test.
//
// channel | dir | handshake        | transaction carries
// --------+-----+------------------+-------------------------------------------
// box     | in  | valid / ready    | min_x..max_z (Q16.16), side_planes_only
// result  | out | valid / ready    | verdict (inside, intersecting, outside)
// cfg     | in  | valid / ready    | index (matrix pair), data (two Q16.16 words)
//
// One box per cycle while the result side takes verdicts. The box transaction edge loads
// s1; its verdict then moves through s2 and s3 and is offered from s4.
// Stages: s1 box register, s2 corner products, s3 distance signs, s4 verdict.
// The throughput is set by the 36 corner multipliers, one set per stage 2 slot.
// Reset clears valid bits and the matrix (all planes zero); no clearing pass.
// A stall on the result side holds each occupied stage; empty stages keep
// filling, so boxes are still taken while a verdict waits, until every stage is full.
module frustum_box_cull import fbc_pkg::*; #(
	parameter int COORD_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	fbc_box_if.sink       box,
	fbc_verdict_if.source result,
	fbc_cfg_if.sink       cfg
);

	plane_t                       planes [NUM_PLANES];
	logic signed [COORD_BITS-1:0] in_min [NUM_AXES];
	logic signed [COORD_BITS-1:0] in_max [NUM_AXES];
	logic signed [COORD_BITS-1:0] box_min_s1 [NUM_AXES];
	logic signed [COORD_BITS-1:0] box_max_s1 [NUM_AXES];
	logic                         side_s1;
	logic                         side_s2;
	logic                         side_s3;
	logic                         v_s1;
	logic                         v_s2;
	logic                         v_s3;
	logic                         v_s4;
	verdict_t                     verdict_s4;
	verdict_t                     verdict_c;
	logic [NUM_PLANES-1:0]        pos_behind_s3;
	logic [NUM_PLANES-1:0]        neg_behind_s3;
	logic [NUM_PLANES-1:0]        plane_mask;
	logic                         en1;
	logic                         en2;
	logic                         en3;
	logic                         en4;
	adv_t                         adv;

	// Advance a stage when it is empty or its successor advances.
	assign en4 = !v_s4 || result.ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign adv = '{s2: en2, s3: en3};

	assign box.ready = en1;

	fbc_plane_regs u_plane_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.planes (planes)
	);

	// Keep only the low COORD_BITS of each coordinate, as a signed value.
	always_comb begin
		in_min[0] = box.min_x[COORD_BITS-1:0];
		in_min[1] = box.min_y[COORD_BITS-1:0];
		in_min[2] = box.min_z[COORD_BITS-1:0];
		in_max[0] = box.max_x[COORD_BITS-1:0];
		in_max[1] = box.max_y[COORD_BITS-1:0];
		in_max[2] = box.max_z[COORD_BITS-1:0];
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= box.valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// Payload registers: no reset needed.
	always_ff @(posedge clk) begin
		if (en1) begin
			box_min_s1 <= in_min;
			box_max_s1 <= in_max;
			side_s1    <= box.side_planes_only;
		end
		if (en2) begin
			side_s2 <= side_s1;
		end
		if (en3) begin
			side_s3 <= side_s2;
		end
		if (en4) begin
			verdict_s4 <= verdict_c;
		end
	end

	for (genvar i = 0; i < NUM_PLANES; i++) begin : g_plane
		fbc_side_test #(
			.COORD_BITS (COORD_BITS)
		) u_side_test (
			.clk           (clk),
			.adv           (adv),
			.plane         (planes[i]),
			.box_min_s1    (box_min_s1),
			.box_max_s1    (box_max_s1),
			.pos_behind_s3 (pos_behind_s3[i]),
			.neg_behind_s3 (neg_behind_s3[i])
		);
	end

	// Drop near and far from the test in side-planes-only mode. Any positive
	// corner behind a tested plane wins over every negative-corner hit.
	always_comb begin
		for (int i = 0; i < NUM_PLANES; i++) begin
			plane_mask[i] = !side_s3 || (i < NUM_SIDE_PLANES);
		end
		if (|(pos_behind_s3 & plane_mask)) begin
			verdict_c = VERDICT_OUTSIDE;
		end else if (|(neg_behind_s3 & plane_mask)) begin
			verdict_c = VERDICT_INTERSECT;
		end else begin
			verdict_c = VERDICT_INSIDE;
		end
	end

	assign result.valid   = v_s4;
	assign result.verdict = verdict_s4;

endmodule

// File: hdl/fbc_plane_regs.sv
// Matrix registers and the six derived clip planes, updated on the write edge.
// Depends on fbc_pkg and fbc_cfg_if.
module fbc_plane_regs import fbc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	fbc_cfg_if.sink      cfg,
	output plane_t       planes [NUM_PLANES]
);

	matrix_t matrix_q;
	matrix_t matrix_nxt;
	plane_t  planes_q [NUM_PLANES];
	logic    wr_hit;

	assign cfg.ready = 1'b1;
	assign wr_hit    = cfg.valid && (cfg.index < CFG_INDEX_BITS'(NUM_PAIRS));

	always_comb begin
		matrix_nxt = matrix_q;
		matrix_nxt[cfg.index[2:0]] = cfg.data;
	end

	// Derive planes from the matrix as it will be after the write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_q <= '0;
			for (int i = 0; i < NUM_PLANES; i++) begin
				planes_q[i] <= '0;
			end
		end else if (wr_hit) begin
			matrix_q <= matrix_nxt;
			for (int i = 0; i < NUM_PLANES; i++) begin
				planes_q[i] <= make_plane(matrix_nxt, PLANE_ROW[i], PLANE_SUB[i]);
			end
		end
	end

	assign planes = planes_q;

endmodule

// File: hdl/fbc_side_test.sv
// One clip plane: corner products (stage 2) and exact distance signs (stage 3).
// Depends on fbc_pkg.
module fbc_side_test import fbc_pkg::*; #(
	parameter int COORD_BITS = 32
) (
	input  logic                         clk,
	input  adv_t                         adv,
	input  plane_t                       plane,
	input  logic signed [COORD_BITS-1:0] box_min_s1 [NUM_AXES],
	input  logic signed [COORD_BITS-1:0] box_max_s1 [NUM_AXES],
	output logic                         pos_behind_s3,
	output logic                         neg_behind_s3
);

	localparam int PROD_BITS = COEF_BITS + COORD_BITS;
	localparam int SUM_BITS  = PROD_BITS + 2;

	logic signed [COORD_BITS-1:0] pos_c [NUM_AXES];
	logic signed [COORD_BITS-1:0] neg_c [NUM_AXES];
	logic signed [PROD_BITS-1:0]  pos_prod_s2 [NUM_AXES];
	logic signed [PROD_BITS-1:0]  neg_prod_s2 [NUM_AXES];
	logic signed [SUM_BITS-1:0]   d_term;
	logic signed [SUM_BITS-1:0]   pos_sum;
	logic signed [SUM_BITS-1:0]   neg_sum;

	// Non-negative component takes max for the positive corner.
	always_comb begin
		for (int k = 0; k < NUM_AXES; k++) begin
			if (plane.a[k][COEF_BITS-1]) begin
				pos_c[k] = box_min_s1[k];
				neg_c[k] = box_max_s1[k];
			end else begin
				pos_c[k] = box_max_s1[k];
				neg_c[k] = box_min_s1[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			for (int k = 0; k < NUM_AXES; k++) begin
				pos_prod_s2[k] <= $signed(plane.a[k]) * pos_c[k];
				neg_prod_s2[k] <= $signed(plane.a[k]) * neg_c[k];
			end
		end
	end

	always_comb begin
		d_term  = SUM_BITS'($signed(plane.d)) <<< FRAC_BITS;
		pos_sum = SUM_BITS'(pos_prod_s2[0]) + SUM_BITS'(pos_prod_s2[1])
			+ SUM_BITS'(pos_prod_s2[2]) + d_term;
		neg_sum = SUM_BITS'(neg_prod_s2[0]) + SUM_BITS'(neg_prod_s2[1])
			+ SUM_BITS'(neg_prod_s2[2]) + d_term;
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			pos_behind_s3 <= pos_sum[SUM_BITS-1];
			neg_behind_s3 <= neg_sum[SUM_BITS-1];
		end
	end

endmodule

// File: tb/frustum_box_cull_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for frustum_box_cull: directed boxes, then random boxes over
// several frustum matrices, each verdict checked by hand or by a local culling predictor.
// Depends on fbc_pkg, the box, verdict and cfg channel interfaces and the block's RTL.
module frustum_box_cull_test;
	import fbc_pkg::*;

	localparam int COORD_BITS  = 32;
	localparam int DIST_BITS   = 72;  // wide enough for a Q32.32 sum of three products
	localparam int FRAC        = 16;
	localparam int CLIP_W_ROW  = 3;
	localparam int QUIET_LIMIT = 1000;
	localparam int TAIL_CYCLES = 8;
	localparam int SOAK_ITEMS  = 155;
	localparam int DIR_ROWS    = 25;

	localparam logic signed [31:0] Q_ONE  = 32'sh0001_0000;
	localparam logic signed [31:0] Q_HALF = 32'sh0000_8000;
	localparam logic signed [31:0] Q_LOW  = 32'sh8000_0000;
	localparam logic signed [31:0] Q_HIGH = 32'sh7FFF_FFFF;

	localparam logic signed [31:0] EDGE_VALUES [5] = '{Q_LOW, Q_HIGH, 0, -1, Q_ONE};

	// Clip plane order: top, bottom, left, right, near, far.
	// Each is row 4 plus or minus the listed row.
	localparam int CLIP_ROW      [NUM_PLANES] = '{1, 1, 0, 0, 2, 2};
	localparam bit CLIP_SUBTRACT [NUM_PLANES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

	typedef enum logic [3:0] {
		MTX_CLEARED,
		MTX_NEG_W,
		MTX_POS_W,
		MTX_IDENTITY,
		MTX_PERSPECTIVE,
		MTX_ALL_LOW,
		MTX_ALL_HIGH,
		MTX_ALL_ONES,
		MTX_RANDOM,
		MTX_JITTERED
	} matrix_preset_t;

	typedef struct packed {
		logic signed [31:0] min_x;
		logic signed [31:0] min_y;
		logic signed [31:0] min_z;
		logic signed [31:0] max_x;
		logic signed [31:0] max_y;
		logic signed [31:0] max_z;
		logic               side_planes_only;
	} box_t;

	// One directed box: the matrix it runs under, and a hand-typed verdict where by_hand is set.
	typedef struct packed {
		matrix_preset_t preset;
		box_t           box;
		logic           by_hand;
		verdict_t       want;
	} box_row_t;

	localparam box_row_t DIRECTED_BOXES [DIR_ROWS] = '{
		// cleared matrix: every plane reads 0 >= 0, so nothing is culled
		'{MTX_CLEARED, '{0, 0, 0, 0, 0, 0, 1'b0}, 1'b1, VERDICT_INSIDE},
		'{MTX_CLEARED, '{Q_LOW, Q_LOW, Q_LOW, Q_HIGH, Q_HIGH, Q_HIGH, 1'b1}, 1'b1, VERDICT_INSIDE},
		'{MTX_CLEARED, '{Q_HIGH, Q_HIGH, Q_HIGH, Q_LOW, Q_LOW, Q_LOW, 1'b0}, 1'b1, VERDICT_INSIDE},
		// zero normals with a negative w term: every box is culled
		'{MTX_NEG_W, '{0, 0, 0, 0, 0, 0, 1'b0}, 1'b1, VERDICT_OUTSIDE},
		'{MTX_NEG_W, '{Q_LOW, Q_LOW, Q_LOW, Q_HIGH, Q_HIGH, Q_HIGH, 1'b1}, 1'b1, VERDICT_OUTSIDE},
		// zero normals with a positive w term: every box passes
		'{MTX_POS_W, '{Q_LOW, Q_LOW, Q_LOW, Q_HIGH, Q_HIGH, Q_HIGH, 1'b0}, 1'b1, VERDICT_INSIDE},
		// unit cube frustum: well inside, touching the planes, straddling, beyond
		'{MTX_IDENTITY, '{-Q_HALF, -Q_HALF, -Q_HALF, Q_HALF, Q_HALF, Q_HALF, 1'b0},
			1'b0, VERDICT_INSIDE},
		'{MTX_IDENTITY, '{-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE, 1'b0},
			1'b0, VERDICT_INSIDE},
		'{MTX_IDENTITY, '{-2*Q_ONE, -2*Q_ONE, -2*Q_ONE, 2*Q_ONE, 2*Q_ONE, 2*Q_ONE, 1'b0},
			1'b0, VERDICT_INSIDE},
		'{MTX_IDENTITY, '{2*Q_ONE, -Q_HALF, -Q_HALF, 3*Q_ONE, Q_HALF, Q_HALF, 1'b0},
			1'b0, VERDICT_INSIDE},
		'{MTX_IDENTITY, '{-Q_HALF, -Q_HALF, 5*Q_ONE, Q_HALF, Q_HALF, 6*Q_ONE, 1'b1},
			1'b0, VERDICT_INSIDE},
		'{MTX_IDENTITY, '{-Q_HALF, -Q_HALF, 5*Q_ONE, Q_HALF, Q_HALF, 6*Q_ONE, 1'b0},
			1'b0, VERDICT_INSIDE},
		'{MTX_IDENTITY, '{Q_ONE, Q_ONE, Q_ONE, -Q_ONE, -Q_ONE, -Q_ONE, 1'b0},
			1'b0, VERDICT_INSIDE},
		'{MTX_IDENTITY, '{Q_HALF, -Q_HALF, -Q_HALF, 3*Q_HALF, Q_HALF, Q_HALF, 1'b0},
			1'b0, VERDICT_INSIDE},
		'{MTX_IDENTITY, '{Q_LOW, Q_LOW, Q_LOW, Q_HIGH, Q_HIGH, Q_HIGH, 1'b0},
			1'b0, VERDICT_INSIDE},
		// perspective frustum, near at 1 and far at 3 down negative z
		'{MTX_PERSPECTIVE, '{-Q_HALF, -Q_HALF, -5*Q_HALF, Q_HALF, Q_HALF, -3*Q_HALF, 1'b0},
			1'b0, VERDICT_INSIDE},
		'{MTX_PERSPECTIVE, '{-Q_HALF, -Q_HALF, Q_ONE, Q_HALF, Q_HALF, 2*Q_ONE, 1'b0},
			1'b0, VERDICT_INSIDE},
		'{MTX_PERSPECTIVE, '{-Q_HALF, -Q_HALF, -5*Q_ONE, Q_HALF, Q_HALF, -4*Q_ONE, 1'b0},
			1'b0, VERDICT_INSIDE},
		'{MTX_PERSPECTIVE, '{-Q_HALF, -Q_HALF, -3*Q_HALF, Q_HALF, Q_HALF, -Q_HALF, 1'b0},
			1'b0, VERDICT_INSIDE},
		'{MTX_PERSPECTIVE, '{Q_LOW, Q_LOW, Q_LOW, Q_HIGH, Q_HIGH, Q_HIGH, 1'b1},
			1'b0, VERDICT_INSIDE},
		// extreme matrix words: widest plane coefficients
		'{MTX_ALL_LOW, '{Q_LOW, Q_LOW, Q_LOW, Q_HIGH, Q_HIGH, Q_HIGH, 1'b0}, 1'b0, VERDICT_INSIDE},
		'{MTX_ALL_LOW, '{0, 0, 0, 0, 0, 0, 1'b1}, 1'b0, VERDICT_INSIDE},
		'{MTX_ALL_HIGH, '{Q_LOW, Q_LOW, Q_LOW, Q_HIGH, Q_HIGH, Q_HIGH, 1'b0}, 1'b0, VERDICT_INSIDE},
		'{MTX_ALL_HIGH, '{-Q_HALF, -Q_HALF, -Q_HALF, Q_HALF, Q_HALF, Q_HALF, 1'b1},
			1'b0, VERDICT_INSIDE},
		'{MTX_ALL_ONES, '{-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE, 1'b0},
			1'b0, VERDICT_INSIDE}
	};

	// Random soak: one matrix per phase, extremes among them.
	localparam matrix_preset_t SOAK_PHASES [10] = '{
		MTX_IDENTITY, MTX_JITTERED, MTX_PERSPECTIVE, MTX_RANDOM, MTX_JITTERED,
		MTX_ALL_LOW, MTX_JITTERED, MTX_ALL_HIGH, MTX_RANDOM, MTX_JITTERED
	};

	logic clk;
	logic arst_n;

	fbc_box_if     box_ch ();
	fbc_verdict_if verdict_ch ();
	fbc_cfg_if     cfg_ch ();

	frustum_box_cull #(.COORD_BITS(COORD_BITS)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.box    (box_ch),
		.result (verdict_ch),
		.cfg    (cfg_ch)
	);

	// Local copy of the matrix registers, updated on each accepted cfg write to a matrix pair.
	matrix_t  cull_matrix = '0;
	verdict_t pending_verdicts [$];
	int       mismatches   = 0;
	int       results_seen = 0;
	int       quiet_cycles = 0;
	bit       calm         = 1'b0;  // set to run a phase with no gaps on either side

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Gap length in cycles: mostly none, sometimes short, rarely long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Matrix element m(row, col), column-major, sign-extended.
	function automatic logic signed [33:0] word_at(int row, int col);
		int                 w;
		logic signed [31:0] word;
		w    = col * NUM_COLS + row;
		word = w[0] ? cull_matrix[w / 2][63:32] : cull_matrix[w / 2][31:0];
		return word;
	endfunction

	function automatic logic signed [33:0] plane_coef(int plane, int col);
		return CLIP_SUBTRACT[plane] ? word_at(CLIP_W_ROW, col) - word_at(CLIP_ROW[plane], col)
			: word_at(CLIP_W_ROW, col) + word_at(CLIP_ROW[plane], col);
	endfunction

	// Predict the verdict: for each plane, the far corner (along the normal) decides
	// outside, the near corner (against it) decides intersecting. A zero distance
	// counts as in front; a zero normal component picks the maximum as far corner.
	function automatic verdict_t classify_box(box_t b);
		logic signed [31:0]          lo [NUM_AXES];
		logic signed [31:0]          hi [NUM_AXES];
		logic signed [33:0]          coef;
		logic signed [DIST_BITS-1:0] reach;
		logic signed [DIST_BITS-1:0] trail;
		verdict_t                    verdict;
		int                          planes;
		lo[0]   = b.min_x;
		lo[1]   = b.min_y;
		lo[2]   = b.min_z;
		hi[0]   = b.max_x;
		hi[1]   = b.max_y;
		hi[2]   = b.max_z;
		planes  = b.side_planes_only ? NUM_SIDE_PLANES : NUM_PLANES;
		verdict = VERDICT_INSIDE;
		for (int p = 0; p < planes && verdict != VERDICT_OUTSIDE; p++) begin
			// d is Q16.16, the products are Q32.32: line d up before summing
			reach = plane_coef(p, NUM_AXES);
			reach = reach <<< FRAC;
			trail = reach;
			for (int k = 0; k < NUM_AXES; k++) begin
				coef = plane_coef(p, k);
				if (coef >= 0) begin
					reach += coef * hi[k];
					trail += coef * lo[k];
				end else begin
					reach += coef * lo[k];
					trail += coef * hi[k];
				end
			end
			if (reach < 0) begin
				verdict = VERDICT_OUTSIDE;
			end else if (trail < 0) begin
				verdict = VERDICT_INTERSECT;
			end
		end
		return verdict;
	endfunction

	function automatic matrix_t preset_matrix(matrix_preset_t preset);
		logic [31:0]    w [16];
		matrix_t        m;
		matrix_preset_t shape;
		foreach (w[i]) w[i] = '0;
		shape = preset;
		if (preset == MTX_JITTERED) begin
			shape = $urandom_range(0, 1) ? MTX_IDENTITY : MTX_PERSPECTIVE;
		end
		case (shape)
			MTX_NEG_W: begin
				w[15] = -Q_ONE;
			end
			MTX_POS_W: begin
				w[15] = Q_ONE;
			end
			MTX_IDENTITY: begin
				w[0]  = Q_ONE;
				w[5]  = Q_ONE;
				w[10] = Q_ONE;
				w[15] = Q_ONE;
			end
			MTX_PERSPECTIVE: begin
				// near 1, far 3: m22 = -2, m23 = -3, m32 = -1, m33 = 0
				w[0]  = Q_ONE;
				w[5]  = Q_ONE;
				w[10] = -2 * Q_ONE;
				w[11] = -Q_ONE;
				w[14] = -3 * Q_ONE;
			end
			MTX_ALL_LOW: begin
				foreach (w[i]) w[i] = Q_LOW;
			end
			MTX_ALL_HIGH: begin
				foreach (w[i]) w[i] = Q_HIGH;
			end
			MTX_ALL_ONES: begin
				foreach (w[i]) w[i] = '1;
			end
			MTX_RANDOM: begin
				foreach (w[i]) w[i] = $urandom;
			end
			default: begin
			end
		endcase
		// nudge about a quarter of the words by up to half a unit, leave the rest exact
		// (zeros stay common)
		if (preset == MTX_JITTERED) begin
			foreach (w[i]) begin
				if ($urandom_range(0, 3) == 0) w[i] += int'($urandom_range(0, Q_ONE)) - Q_HALF;
			end
		end
		for (int k = 0; k < NUM_PAIRS; k++) m[k] = {w[2*k+1], w[2*k]};
		return m;
	endfunction

	// Mostly well-formed boxes near the unit frustum; some raw, extreme or inverted.
	function automatic box_t random_box();
		logic signed [31:0] lo [NUM_AXES];
		logic signed [31:0] hi [NUM_AXES];
		logic signed [31:0] centre;
		logic signed [31:0] half;
		logic signed [31:0] t;
		int                 pick;
		pick = $urandom_range(0, 19);
		for (int k = 0; k < NUM_AXES; k++) begin
			if (pick == 0) begin
				lo[k] = $urandom;
				hi[k] = $urandom;
			end else if (pick == 1) begin
				lo[k] = EDGE_VALUES[$urandom_range(0, 4)];
				hi[k] = EDGE_VALUES[$urandom_range(0, 4)];
			end else begin
				centre = int'($urandom_range(0, 10 * Q_ONE)) - 5 * Q_ONE;
				half   = $urandom_range(0, 3 * Q_ONE);
				// snap to half units now and then so corners land exactly on planes
				if (pick < 7) begin
					centre = (centre / Q_HALF) * Q_HALF;
					half   = (half / Q_HALF) * Q_HALF;
				end
				lo[k] = centre - half;
				hi[k] = centre + half;
			end
			if (pick == 2) begin
				t     = lo[k];
				lo[k] = hi[k];
				hi[k] = t;
			end
		end
		return '{lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], 1'($urandom_range(0, 1))};
	endfunction

	// Offer one box after a random gap, hold it until taken, then log its verdict.
	task automatic send_box(box_t b, verdict_t want);
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			box_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		box_ch.valid            <= 1'b1;
		box_ch.min_x            <= b.min_x;
		box_ch.min_y            <= b.min_y;
		box_ch.min_z            <= b.min_z;
		box_ch.max_x            <= b.max_x;
		box_ch.max_y            <= b.max_y;
		box_ch.max_z            <= b.max_z;
		box_ch.side_planes_only <= b.side_planes_only;
		do @(posedge clk); while (!box_ch.ready);
		pending_verdicts.push_back(want);
	endtask

	// Drop valid and wait until every verdict is back: the block is then idle.
	task automatic drain_boxes();
		box_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
	endtask

	// Leaves valid high; load_matrix lowers it once the whole set is written.
	task automatic write_pair(int idx, logic [PAIR_BITS-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= CFG_INDEX_BITS'(idx);
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx < NUM_PAIRS) cull_matrix[idx] = data;
	endtask

	task automatic load_matrix(matrix_preset_t preset);
		matrix_t m;
		m = preset_matrix(preset);
		for (int k = 0; k < NUM_PAIRS; k++) write_pair(k, m[k]);
		// an index past the eight pairs must leave the matrix untouched
		if (preset == MTX_RANDOM || preset == MTX_JITTERED) begin
			write_pair($urandom_range(NUM_PAIRS, 2**CFG_INDEX_BITS - 1), {$urandom, $urandom});
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// Result side: check each verdict transaction, then decide whether to stall next cycle.
	initial begin
		verdict_t want;
		int       stall_left;
		int       gap;
		verdict_ch.ready = 1'b0;
		stall_left       = 0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (verdict_ch.valid && verdict_ch.ready) begin
					results_seen++;
					if (pending_verdicts.size() == 0) begin
						if (mismatches < 10) begin
							$display("verdict %0d arrived with no box outstanding: got %0d",
								results_seen, verdict_ch.verdict);
						end
						mismatches++;
					end else begin
						want = pending_verdicts.pop_front();
						if (verdict_ch.verdict !== want) begin
							if (mismatches < 10) begin
								$display("verdict %0d mismatch: expected %0d, got %0d",
									results_seen, want, verdict_ch.verdict);
							end
							mismatches++;
						end
					end
				end
				if (stall_left != 0) begin
					verdict_ch.ready <= 1'b0;
					stall_left--;
				end else begin
					gap               = pick_gap();
					verdict_ch.ready <= (gap == 0);
					stall_left        = (gap == 0) ? 0 : gap - 1;
				end
			end
		end
	end

	// Watchdog: end the run if no channel completes a transaction for too long.
	always @(posedge clk) begin
		if (!arst_n || (box_ch.valid && box_ch.ready) || (verdict_ch.valid && verdict_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("frustum_box_cull_test NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Stimulus: reset, directed boxes, then the random soak phases.
	initial begin
		matrix_preset_t loaded;
		box_t           b;
		verdict_t       want;
		arst_n                  = 1'b0;
		box_ch.valid            = 1'b0;
		box_ch.min_x            = '0;
		box_ch.min_y            = '0;
		box_ch.min_z            = '0;
		box_ch.max_x            = '0;
		box_ch.max_y            = '0;
		box_ch.max_z            = '0;
		box_ch.side_planes_only = 1'b0;
		cfg_ch.valid            = 1'b0;
		cfg_ch.index            = '0;
		cfg_ch.data             = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: reload the matrix only when the row's preset changes.
		loaded = MTX_CLEARED;
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (DIRECTED_BOXES[i].preset != loaded) begin
				drain_boxes();
				loaded = DIRECTED_BOXES[i].preset;
				load_matrix(loaded);
			end
			b    = DIRECTED_BOXES[i].box;
			want = DIRECTED_BOXES[i].by_hand ? DIRECTED_BOXES[i].want : classify_box(b);
			send_box(b, want);
		end

		// Random part: every fourth phase runs without gaps on either side.
		for (int ph = 0; ph < $size(SOAK_PHASES); ph++) begin
			drain_boxes();
			calm = (ph % 4 == 2);
			load_matrix(SOAK_PHASES[ph]);
			repeat (SOAK_ITEMS) begin
				b = random_box();
				send_box(b, classify_box(b));
			end
		end

		// Let the pipeline empty, then wait out the tail for any stray verdict.
		drain_boxes();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_verdicts.size() == 0) begin
			$display("frustum_box_cull_test OK");
		end else begin
			$display("frustum_box_cull_test NOT OK");
		end
		$finish;
	end

endmodule
